[rtl/wcss_pkg.sv]
// Shared constants, types and helpers for the window count square sum block.
package wcss_pkg;

	localparam int ARRAY_DEPTH = 1024;
	localparam int VALUE_RANGE = 1024;

	localparam int IDX_W    = 11;
	localparam int VAL_IN_W = 10;
	localparam int LEN_W    = 11;
	localparam int SUM_W    = 21;

	localparam int ADDR_W  = $clog2(ARRAY_DEPTH);
	localparam int VADDR_W = $clog2(VALUE_RANGE);
	localparam int CNT_W   = $clog2(ARRAY_DEPTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_ARRAY_LENGTH = '0;

	typedef enum logic [1:0] {
		K_LOAD  = 2'd0,
		K_QUERY = 2'd1,
		K_BAD   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   pos;
		logic [VADDR_W-1:0] val;
		logic [IDX_W-1:0]   lo;
		logic [IDX_W-1:0]   hi;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	function automatic logic [VADDR_W-1:0] clamp_value(input logic [VAL_IN_W-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 >= 32'(VALUE_RANGE))
			return VADDR_W'(VALUE_RANGE - 1);
		return VADDR_W'(v);
	endfunction

endpackage

[rtl/wcss_front.sv]
// Front end: accepts requests, classifies them, drops loads outside the array and queues the rest for the back end.
module wcss_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [wcss_pkg::IDX_W-1:0]          position,
	input  logic [wcss_pkg::VAL_IN_W-1:0]       element_value,
	input  logic [wcss_pkg::IDX_W-1:0]          left_end,
	input  logic [wcss_pkg::IDX_W-1:0]          right_end,
	input  logic [wcss_pkg::LEN_W-1:0]          array_length,
	input  wcss_pkg::back_ctl_t                 ctl,
	output logic                                head_valid,
	output wcss_pkg::entry_t                    head
);

	wcss_pkg::entry_t                  queue_q [wcss_pkg::QUEUE_DEPTH];
	logic [wcss_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [wcss_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [wcss_pkg::QCNT_W-1:0]       count_q;
	wcss_pkg::entry_t                  entry;
	logic                              accept;
	logic                              drop;
	logic                              push;
	logic                              pop;

	assign in_stall   = (count_q == wcss_pkg::QCNT_W'(wcss_pkg::QUEUE_DEPTH)) || ctl.clearing;
	assign accept     = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];
	assign pop        = ctl.pop && head_valid;

	always_comb begin
		entry.pos = position;
		entry.val = wcss_pkg::clamp_value(element_value);
		entry.lo  = left_end;
		entry.hi  = right_end;
		drop      = 1'b0;
		if (!operation) begin
			entry.kind = wcss_pkg::K_LOAD;
			drop       = (position == '0) || (position > array_length);
		end else if ((left_end == '0) || (left_end > right_end) ||
			(right_end > array_length)) begin
			entry.kind = wcss_pkg::K_BAD;
		end else begin
			entry.kind = wcss_pkg::K_QUERY;
		end
	end

	assign push = accept && !drop;

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == wcss_pkg::QPTR_W'(wcss_pkg::QUEUE_DEPTH - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + wcss_pkg::QPTR_W'(1);
			end
			if (pop) begin
				if (rd_ptr_q == wcss_pkg::QPTR_W'(wcss_pkg::QUEUE_DEPTH - 1))
					rd_ptr_q <= '0;
				else
					rd_ptr_q <= rd_ptr_q + wcss_pkg::QPTR_W'(1);
			end
			if (push && !pop)
				count_q <= count_q + wcss_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - wcss_pkg::QCNT_W'(1);
		end
	end

endmodule

[rtl/wcss_back.sv]
// Back end: element and count memories, window walk sequencer and result register.
module wcss_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  wcss_pkg::entry_t              head,
	output wcss_pkg::back_ctl_t           ctl,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wcss_pkg::SUM_W-1:0]    square_sum,
	output logic                          status
);

	typedef enum logic [7:0] {
		S_CLEAR   = 8'b0000_0001,
		S_IDLE    = 8'b0000_0010,
		S_PICK    = 8'b0000_0100,
		S_RD_ELEM = 8'b0000_1000,
		S_RD_CNT  = 8'b0001_0000,
		S_UPD     = 8'b0010_0000,
		S_WR_ELEM = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	logic [wcss_pkg::VADDR_W-1:0] elem_mem [wcss_pkg::ARRAY_DEPTH];
	logic [wcss_pkg::CNT_W-1:0]   cnt_mem  [wcss_pkg::VALUE_RANGE];

	state_t                       state_q;
	logic [wcss_pkg::VADDR_W-1:0] clr_idx_q;
	logic [wcss_pkg::SUM_W-1:0]   sum_q;
	logic [wcss_pkg::IDX_W-1:0]   left_q;
	logic [wcss_pkg::IDX_W-1:0]   right_q;
	logic [wcss_pkg::IDX_W-1:0]   lo_q;
	logic [wcss_pkg::IDX_W-1:0]   hi_q;
	logic                         is_load_q;
	logic                         bad_q;
	logic                         step_enter_q;
	logic                         step_direct_q;
	logic [wcss_pkg::ADDR_W-1:0]  step_addr_q;
	logic [wcss_pkg::VADDR_W-1:0] load_val_q;
	logic [wcss_pkg::VADDR_W-1:0] elem_rd_q;
	logic [wcss_pkg::CNT_W-1:0]   cnt_rd_q;
	logic [wcss_pkg::VADDR_W-1:0] cnt_addr_q;
	logic                         out_valid_q;
	logic [wcss_pkg::SUM_W-1:0]   out_sum_q;
	logic                         out_status_q;

	logic                         pick_any;
	logic                         pick_enter;
	logic [wcss_pkg::IDX_W-1:0]   pick_idx;
	logic [wcss_pkg::IDX_W-1:0]   pick_addr_full;
	logic [wcss_pkg::IDX_W-1:0]   left_nx;
	logic [wcss_pkg::IDX_W-1:0]   right_nx;
	logic [wcss_pkg::IDX_W-1:0]   pos_addr_full;
	logic                         in_window;
	logic [wcss_pkg::VADDR_W-1:0] cnt_raddr;
	logic [wcss_pkg::CNT_W-1:0]   cnt_dec;
	logic [wcss_pkg::CNT_W-1:0]   cnt_new;
	logic [wcss_pkg::SUM_W-1:0]   sum_new;
	logic                         cnt_zero;
	logic                         cnt_we;
	logic [wcss_pkg::VADDR_W-1:0] cnt_waddr;
	logic [wcss_pkg::CNT_W-1:0]   cnt_wdata;
	logic                         elem_we;
	logic                         out_free;

	assign ctl.pop      = (state_q == S_IDLE) && head_valid;
	assign ctl.clearing = (state_q == S_CLEAR);
	assign out_free     = !out_valid_q || !out_stall;

	// grow first, then shrink, so no count falls below zero
	always_comb begin
		pick_any   = 1'b1;
		pick_enter = 1'b1;
		left_nx    = left_q;
		right_nx   = right_q;
		pick_idx   = left_q;
		if (left_q > lo_q) begin
			left_nx  = left_q - wcss_pkg::IDX_W'(1);
			pick_idx = left_q - wcss_pkg::IDX_W'(1);
		end else if (right_q < hi_q) begin
			right_nx = right_q + wcss_pkg::IDX_W'(1);
			pick_idx = right_q + wcss_pkg::IDX_W'(1);
		end else if (right_q > hi_q) begin
			pick_enter = 1'b0;
			pick_idx   = right_q;
			right_nx   = right_q - wcss_pkg::IDX_W'(1);
		end else if (left_q < lo_q) begin
			pick_enter = 1'b0;
			pick_idx   = left_q;
			left_nx    = left_q + wcss_pkg::IDX_W'(1);
		end else begin
			pick_any = 1'b0;
		end
	end

	assign pick_addr_full = pick_idx - wcss_pkg::IDX_W'(1);
	assign pos_addr_full  = head.pos - wcss_pkg::IDX_W'(1);
	assign in_window      = (head.pos >= left_q) && (head.pos <= right_q);

	assign cnt_raddr = step_direct_q ? load_val_q : elem_rd_q;
	assign cnt_zero  = (cnt_rd_q == '0);
	assign cnt_dec   = cnt_rd_q - wcss_pkg::CNT_W'(1);
	assign cnt_new   = step_enter_q ? (cnt_rd_q + wcss_pkg::CNT_W'(1)) : cnt_dec;
	// 2c+1 on entry, 2(c-1)+1 on exit
	assign sum_new   = step_enter_q ?
		(sum_q + {{(wcss_pkg::SUM_W - wcss_pkg::CNT_W - 1){1'b0}}, cnt_rd_q, 1'b1}) :
		(sum_q - {{(wcss_pkg::SUM_W - wcss_pkg::CNT_W - 1){1'b0}}, cnt_dec, 1'b1});

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = cnt_addr_q;
		cnt_wdata = cnt_new;
		if (state_q == S_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_idx_q;
			cnt_wdata = '0;
		end else if (state_q == S_UPD) begin
			cnt_we = step_enter_q || !cnt_zero;
		end
	end

	assign elem_we = (state_q == S_WR_ELEM);

	always_ff @(posedge clk) begin
		if (elem_we)
			elem_mem[step_addr_q] <= load_val_q;
		elem_rd_q <= elem_mem[step_addr_q];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD_CNT)
			cnt_addr_q <= cnt_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_idx_q     <= '0;
			sum_q         <= '0;
			left_q        <= wcss_pkg::IDX_W'(1);
			right_q       <= '0;
			out_valid_q   <= 1'b0;
			is_load_q     <= 1'b0;
			bad_q         <= 1'b0;
			step_enter_q  <= 1'b0;
			step_direct_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + wcss_pkg::VADDR_W'(1);
					if (clr_idx_q == wcss_pkg::VADDR_W'(wcss_pkg::VALUE_RANGE - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (head_valid) begin
						lo_q          <= head.lo;
						hi_q          <= head.hi;
						load_val_q    <= head.val;
						step_addr_q   <= pos_addr_full[wcss_pkg::ADDR_W-1:0];
						step_enter_q  <= 1'b0;
						step_direct_q <= 1'b0;
						is_load_q     <= (head.kind == wcss_pkg::K_LOAD);
						bad_q         <= (head.kind == wcss_pkg::K_BAD);
						case (head.kind)
							wcss_pkg::K_LOAD:  state_q <= in_window ? S_RD_ELEM : S_WR_ELEM;
							wcss_pkg::K_QUERY: state_q <= S_PICK;
							default:           state_q <= S_DONE;
						endcase
					end
				end
				S_PICK: begin
					left_q  <= left_nx;
					right_q <= right_nx;
					if (pick_any) begin
						step_addr_q   <= pick_addr_full[wcss_pkg::ADDR_W-1:0];
						step_enter_q  <= pick_enter;
						step_direct_q <= 1'b0;
						state_q       <= S_RD_ELEM;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD_ELEM: state_q <= S_RD_CNT;
				S_RD_CNT:  state_q <= S_UPD;
				S_UPD: begin
					if (step_enter_q || !cnt_zero)
						sum_q <= sum_new;
					if (!is_load_q) begin
						state_q <= S_PICK;
					end else if (!step_direct_q) begin
						// old value has left, new value enters next
						step_direct_q <= 1'b1;
						step_enter_q  <= 1'b1;
						state_q       <= S_RD_CNT;
					end else begin
						state_q <= S_WR_ELEM;
					end
				end
				S_WR_ELEM: state_q <= S_IDLE;
				S_DONE: begin
					if (out_free) begin
						out_sum_q    <= bad_q ? '0 : sum_q;
						out_status_q <= bad_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign square_sum = out_sum_q;
	assign status     = out_status_q;

endmodule

[rtl/window_count_square_sum_top.sv]
// Top level: register port, front end queue and back end walk engine.
// Load: outside the window, an element write only; inside it, an element read, two count updates, then the write.
// Query: one walk step per edge move; each step is an element read then a count read-modify-write.
// Bad query: goes straight to the result. One request is worked at a time; two more may wait in the queue.
// Reset clears control state, then a pass over all 1024 entries zeroes the count memory with in_stall high.
// Element memory is not cleared.
module window_count_square_sum_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wcss_pkg::PADDR_W-1:0]        paddr,
	input  logic [wcss_pkg::PDATA_W-1:0]        pwdata,
	output logic [wcss_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [wcss_pkg::IDX_W-1:0]          position,
	input  logic [wcss_pkg::VAL_IN_W-1:0]       element_value,
	input  logic [wcss_pkg::IDX_W-1:0]          left_end,
	input  logic [wcss_pkg::IDX_W-1:0]          right_end,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [wcss_pkg::SUM_W-1:0]          square_sum,
	output logic                                status
);

	logic [wcss_pkg::LEN_W-1:0]     array_length_q;
	logic [wcss_pkg::LEN_W-1:0]     wr_len;
	logic [wcss_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_en;
	logic                           head_valid;
	wcss_pkg::entry_t               head;
	wcss_pkg::back_ctl_t            ctl;

	assign pready  = 1'b1;
	assign reg_idx = paddr[wcss_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign wr_len  = pwdata[wcss_pkg::LEN_W-1:0];
	assign prdata  = (reg_idx == wcss_pkg::REG_ARRAY_LENGTH) ?
		wcss_pkg::PDATA_W'(array_length_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			array_length_q <= wcss_pkg::LEN_W'(wcss_pkg::ARRAY_DEPTH);
		end else if (wr_en && (reg_idx == wcss_pkg::REG_ARRAY_LENGTH)) begin
			if (wr_len == '0)
				array_length_q <= wcss_pkg::LEN_W'(1);
			else if (32'(wr_len) > 32'(wcss_pkg::ARRAY_DEPTH))
				array_length_q <= wcss_pkg::LEN_W'(wcss_pkg::ARRAY_DEPTH);
			else
				array_length_q <= wr_len;
		end
	end

	wcss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.position      (position),
		.element_value (element_value),
		.left_end      (left_end),
		.right_end     (right_end),
		.array_length  (array_length_q),
		.ctl           (ctl),
		.head_valid    (head_valid),
		.head          (head)
	);

	wcss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.ctl        (ctl),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.square_sum (square_sum),
		.status     (status)
	);

endmodule

[tb/wcss_checker.sv]
`timescale 1ns / 1ps
// Checker for the window count square sum block: tracks config, predicts results, compares them.
module wcss_checker
	import wcss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               operation,
	input  logic [IDX_W-1:0]   position,
	input  logic [VAL_IN_W-1:0] element_value,
	input  logic [IDX_W-1:0]   left_end,
	input  logic [IDX_W-1:0]   right_end,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [SUM_W-1:0]   square_sum,
	input  logic               status,
	output int                 fail_count,
	output int                 pending
);

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_BAD = 1'b1;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             st;
	} answer_t;

	answer_t            answers_due[$];
	logic [VADDR_W-1:0] elem_copy [ARRAY_DEPTH];
	int unsigned        hist [VALUE_RANGE];
	longint unsigned    sq_total;
	int unsigned        win_lo;
	int unsigned        win_hi;
	int unsigned        len_cfg;
	int                 mism;

	function automatic int unsigned stored_at(int unsigned idx);
		return elem_copy[(idx - 1) % ARRAY_DEPTH];
	endfunction

	function automatic void count_in(int unsigned v);
		sq_total += 2 * hist[v] + 1;
		hist[v]++;
	endfunction

	function automatic void count_out(int unsigned v);
		if (hist[v] == 0)
			return;
		hist[v]--;
		sq_total -= 2 * hist[v] + 1;
	endfunction

	function automatic void take_config(logic [PDATA_W-1:0] d);
		int unsigned n;
		n = d & 32'h7FF;
		if (n < 1)
			n = 1;
		if (n > ARRAY_DEPTH)
			n = ARRAY_DEPTH;
		len_cfg = n;
	endfunction

	function automatic void take_load(logic [IDX_W-1:0] pos, logic [VAL_IN_W-1:0] v);
		int unsigned p;
		int unsigned nv;
		p  = pos;
		nv = v;
		if (nv >= VALUE_RANGE)
			nv = VALUE_RANGE - 1;
		if (p < 1 || p > len_cfg)
			return;
		// element inside the window swaps its histogram contribution
		if (p >= win_lo && p <= win_hi) begin
			count_out(stored_at(p));
			count_in(nv);
		end
		elem_copy[p - 1] = VADDR_W'(nv);
	endfunction

	function automatic answer_t take_query(logic [IDX_W-1:0] lo_in, logic [IDX_W-1:0] hi_in);
		answer_t     a;
		int unsigned lo;
		int unsigned hi;
		lo = lo_in;
		hi = hi_in;
		if (lo < 1 || lo > hi || hi > len_cfg) begin
			a.sum = '0;
			a.st  = ST_BAD;
			return a;
		end
		// grow first, then shrink
		while (win_lo > lo) begin
			win_lo--;
			count_in(stored_at(win_lo));
		end
		while (win_hi < hi) begin
			win_hi++;
			count_in(stored_at(win_hi));
		end
		while (win_hi > hi) begin
			count_out(stored_at(win_hi));
			win_hi--;
		end
		while (win_lo < lo) begin
			count_out(stored_at(win_lo));
			win_lo++;
		end
		a.sum = sq_total[SUM_W-1:0];
		a.st  = ST_OK;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t seen;
		answer_t want;
		kind_t   op_kind;
		logic    bad;
		if (!arst_n) begin
			for (int i = 0; i < VALUE_RANGE; i++)
				hist[i] = 0;
			for (int i = 0; i < ARRAY_DEPTH; i++)
				elem_copy[i] = '0;
			sq_total = 0;
			win_lo   = 1;
			win_hi   = 0;
			len_cfg  = ARRAY_DEPTH;
			mism     = 0;
			answers_due.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ARRAY_LENGTH)
				take_config(pwdata);
			if (out_valid && !out_stall) begin
				seen.sum = square_sum;
				seen.st  = status;
				if (answers_due.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("unexpected result: square_sum %0d status %0d",
							seen.sum, seen.st);
				end else begin
					want = answers_due.pop_front();
					bad  = 1'b0;
					if (seen.sum !== want.sum)
						bad = 1'b1;
					if (seen.st !== want.st)
						bad = 1'b1;
					if (bad) begin
						mism++;
						if (mism <= 10)
							$display("result: expected square_sum %0d status %0d, got square_sum %0d status %0d",
								want.sum, want.st, seen.sum, seen.st);
					end
				end
			end
			if (in_valid && !in_stall) begin
				op_kind = kind_t'({1'b0, operation});
				if (op_kind == K_QUERY)
					answers_due.push_back(take_query(left_end, right_end));
				else
					take_load(position, element_value);
			end
			fail_count <= mism;
			pending    <= answers_due.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes into the block and gives the verdict.
module tb_top;
	import wcss_pkg::*;

	localparam int CYCLE_LIMIT     = 5_000_000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 100;
	localparam int FILL_DEPTH      = 256;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(1);

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic                operation;
	logic [IDX_W-1:0]    position;
	logic [VAL_IN_W-1:0] element_value;
	logic [IDX_W-1:0]    left_end;
	logic [IDX_W-1:0]    right_end;
	logic                out_valid;
	logic                out_stall;
	logic [SUM_W-1:0]    square_sum;
	logic                status;

	int fail_count;
	int pending;
	int cycle_count = 0;
	bit gaps_on;
	bit hold_req;

	// stimulus-side view of the window and array length
	int unsigned q_lo;
	int unsigned q_hi;
	int unsigned len_now;

	window_count_square_sum_top u_dut (.*);

	wcss_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("window_count_square_sum_top: mismatch");
			$finish;
		end
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int pin(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	task automatic push_req(input kind_t op, input logic [IDX_W-1:0] pos,
			input logic [VAL_IN_W-1:0] val, input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op[0];
		position      <= pos;
		element_value <= val;
		left_end      <= lo;
		right_end     <= hi;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load(input int unsigned pos, input int unsigned val);
		push_req(K_LOAD, IDX_W'(pos), VAL_IN_W'(val), IDX_W'($urandom), IDX_W'($urandom));
	endtask

	task automatic query(input int unsigned lo, input int unsigned hi);
		push_req(K_QUERY, IDX_W'($urandom), VAL_IN_W'($urandom), IDX_W'(lo), IDX_W'(hi));
		if (lo >= 1 && lo <= hi && hi <= len_now) begin
			q_lo = lo;
			q_hi = hi;
		end
	endtask

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
		int unsigned n;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_ARRAY_LENGTH) begin
			n = data & 32'h7FF;
			len_now = pin(int'(n), 1, ARRAY_DEPTH);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_item();
		int unsigned r;
		int unsigned a;
		int unsigned b;
		int unsigned t;
		int unsigned v;
		int unsigned span;
		// valid queries stay within the filled part of the array
		span = (len_now < FILL_DEPTH) ? len_now : FILL_DEPTH;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				case ($urandom_range(0, 2))
					0: begin
						a = 0;
						b = $urandom_range(0, 2047);
					end
					1: begin
						a = $urandom_range(2, 2047);
						b = $urandom_range(1, a - 1);
					end
					default: begin
						b = $urandom_range(len_now + 1, 2047);
						a = $urandom_range(1, b);
					end
				endcase
			end else if (r < 13) begin
				a = $urandom_range(1, span);
				b = $urandom_range(a, span);
			end else begin
				a = pin(int'(q_lo) + int'($urandom_range(0, 12)) - 6, 1, span);
				b = pin(int'(q_hi) + int'($urandom_range(0, 12)) - 6, 1, span);
				if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
			end
			query(a, b);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 10)
				a = $urandom_range(0, 1) ? 0 : $urandom_range(len_now + 1, 2047);
			else if (r < 35)
				a = $urandom_range(1, len_now);
			else begin
				t = $urandom_range(q_lo, (q_hi > q_lo) ? q_hi : q_lo);
				a = pin(int'(t) + int'($urandom_range(0, 8)) - 4, 1, len_now);
			end
			r = $urandom_range(0, 99);
			if (r < 50)
				v = $urandom_range(0, 3);
			else if (r < 60)
				v = $urandom_range(0, 1) ? VALUE_RANGE - 1 : 0;
			else
				v = $urandom_range(0, VALUE_RANGE - 1);
			load(a, v);
		end
	endtask

	initial begin
		logic [PDATA_W-1:0] cfg_plan [8];
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		operation     = 1'b0;
		position      = '0;
		element_value = '0;
		left_end      = '0;
		right_end     = '0;
		gaps_on       = 1'b1;
		hold_req      = 1'b0;
		q_lo          = 1;
		q_hi          = 0;
		len_now       = ARRAY_DEPTH;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the count clearing pass
		do @(posedge clk); while (in_stall);
		apb_write(REG_ARRAY_LENGTH, PDATA_W'(ARRAY_DEPTH));

		// filled part of the array written once, all with the top value
		for (int p = 1; p <= FILL_DEPTH; p++)
			load(p, VALUE_RANGE - 1);

		// directed part
		query(1, FILL_DEPTH);
		query(FILL_DEPTH, FILL_DEPTH);
		query(1, 1);
		query(0, 5);
		query(6, 5);
		query(1, ARRAY_DEPTH + 1);
		query(2047, 2047);
		load(1, 0);
		query(1, 1);
		load(0, 5);
		load(ARRAY_DEPTH + 1, 5);
		load(2047, 7);
		load(ARRAY_DEPTH, 0);
		query(1, 3);
		load(2, 0);
		load(3, 0);
		query(2, 3);
		query(1, FILL_DEPTH);
		load(FILL_DEPTH / 2, VALUE_RANGE - 1);
		load(FILL_DEPTH / 2 + 1, 1);
		query(1, FILL_DEPTH);
		query(1, 1);

		cfg_plan[0] = PDATA_W'(ARRAY_DEPTH);
		cfg_plan[1] = 32'd1;
		cfg_plan[2] = PDATA_W'($urandom_range(2, ARRAY_DEPTH - 1));
		cfg_plan[3] = 32'd0;
		cfg_plan[4] = 32'h0000_07FF;
		cfg_plan[5] = 32'hFFFF_F805;
		cfg_plan[6] = PDATA_W'($urandom_range(16, 200));
		cfg_plan[7] = PDATA_W'(ARRAY_DEPTH);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			apb_write(REG_ARRAY_LENGTH, cfg_plan[ph]);
			if (ph == 3)
				apb_write(REG_UNMAPPED, $urandom);
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 7)
				gaps_on = 1'b0;
			repeat (ITEMS_PER_PHASE) random_item();
		end

		settle();
		if (fail_count == 0)
			$display("window_count_square_sum_top: match");
		else
			$display("window_count_square_sum_top: mismatch");
		$finish;
	end

endmodule
